/* design/deque_with_remove_by_key_core_macros.svh */
// ----------------------------------------------------------------------------
// deque_with_remove_by_key_core_macros
// assertion shorthands shared by the deque core
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_REMOVE_BY_KEY_CORE_MACROS_SVH
`define DEQUE_WITH_REMOVE_BY_KEY_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DWRK_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DWRK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/dwrk_pkg.sv */
// ----------------------------------------------------------------------------
// dwrk_pkg
// types, widths and codes shared by the deque core modules
// ----------------------------------------------------------------------------
package dwrk_pkg;

   localparam int KEY_W         = 24;
   localparam int DATA_W        = 32;
   localparam int REC_W         = KEY_W + DATA_W;
   localparam int DEPTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_PUSH_BACK  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_REMOVE_KEY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RD_FRONT,
      S_RD_BACK,
      S_CAP_BACK,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      ADDR_POS,
      ADDR_POS_NEXT,
      ADDR_TAIL,
      ADDR_NEW_HEAD,
      ADDR_FRONT,
      ADDR_BACK
   } addr_sel_type;

   // controller to datapath
   typedef struct packed {
      logic         load_req;
      logic         mem_we;
      logic         wr_from_mem;
      addr_sel_type addr_sel;
      logic         head_inc;
      logic         head_dec;
      logic         count_inc;
      logic         count_dec;
      logic         pos_clr;
      logic         pos_inc;
      logic         front_cap;
      logic         back_cap;
      logic         view_clr;
      logic         status_we;
      status_type   status_val;
      logic         rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   key_hit;
      logic   scan_last;
      logic   shift_last;
      logic   rsp_busy;
   } dp_sts_type;

endpackage

/* design/dwrk_ram.sv */
// ----------------------------------------------------------------------------
// dwrk_ram
// generic single-address ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module dwrk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* design/dwrk_ctrl.sv */
// ----------------------------------------------------------------------------
// dwrk_ctrl
// sequencer for one item: execute, key scan, gap closing, readout, response
// ----------------------------------------------------------------------------
module dwrk_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  dwrk_pkg::dp_sts_type sts,
   output dwrk_pkg::dp_cmd_type cmd
);

   import dwrk_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.op == OP_REMOVE_KEY && !sts.empty) state_in = S_SCAN_RD;
            else                                        state_in = S_RD_FRONT;
         end
         S_SCAN_RD: state_in = S_SCAN_CMP;
         S_SCAN_CMP: begin
            priority if (sts.key_hit && sts.scan_last) state_in = S_RD_FRONT;
            else if (sts.key_hit)                      state_in = S_SHIFT_RD;
            else if (sts.scan_last)                    state_in = S_RD_FRONT;
            else                                       state_in = S_SCAN_RD;
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: begin
            if (sts.shift_last) state_in = S_RD_FRONT;
            else                state_in = S_SHIFT_RD;
         end
         S_RD_FRONT: begin
            if (sts.empty) state_in = S_DONE;
            else           state_in = S_RD_BACK;
         end
         S_RD_BACK:  state_in = S_CAP_BACK;
         S_CAP_BACK: state_in = S_DONE;
         S_DONE: begin
            if (!sts.rsp_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.addr_sel   = ADDR_POS;
      cmd.status_val = ST_OK;
      req_stall      = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            cmd.status_we = 1'b1;
            unique case (sts.op)
               OP_PUSH_BACK: begin
                  if (sts.full) begin
                     cmd.status_val = ST_FULL;
                  end else begin
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = ADDR_TAIL;
                     cmd.count_inc = 1'b1;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (sts.full) begin
                     cmd.status_val = ST_FULL;
                  end else begin
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = ADDR_NEW_HEAD;
                     cmd.head_dec  = 1'b1;
                     cmd.count_inc = 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (sts.empty) begin
                     cmd.status_val = ST_EMPTY;
                  end else begin
                     cmd.head_inc  = 1'b1;
                     cmd.count_dec = 1'b1;
                  end
               end
               OP_REMOVE_KEY: begin
                  if (sts.empty) cmd.status_val = ST_NOT_FOUND;
                  else           cmd.pos_clr    = 1'b1;
               end
               default: cmd.status_val = ST_OK;
            endcase
         end
         S_SCAN_RD: begin
            cmd.addr_sel = ADDR_POS;
         end
         S_SCAN_CMP: begin
            priority if (sts.key_hit && sts.scan_last) begin
               cmd.count_dec = 1'b1;
            end else if (sts.key_hit) begin
               cmd.status_val = ST_OK;
            end else if (sts.scan_last) begin
               cmd.status_we  = 1'b1;
               cmd.status_val = ST_NOT_FOUND;
            end else begin
               cmd.pos_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.addr_sel = ADDR_POS_NEXT;
         end
         S_SHIFT_WR: begin
            cmd.mem_we      = 1'b1;
            cmd.wr_from_mem = 1'b1;
            cmd.addr_sel    = ADDR_POS;
            if (sts.shift_last) cmd.count_dec = 1'b1;
            else                cmd.pos_inc   = 1'b1;
         end
         S_RD_FRONT: begin
            cmd.addr_sel = ADDR_FRONT;
            cmd.view_clr = sts.empty;
         end
         S_RD_BACK: begin
            cmd.addr_sel  = ADDR_BACK;
            cmd.front_cap = 1'b1;
         end
         S_CAP_BACK: begin
            cmd.back_cap = 1'b1;
         end
         S_DONE: begin
            cmd.rsp_load = !sts.rsp_busy;
         end
         default: cmd.load_req = 1'b0;
      endcase
   end

endmodule

/* design/dwrk_dpath.sv */
// ----------------------------------------------------------------------------
// dwrk_dpath
// ring pointers, record ram, scan position, readout and response registers
// ----------------------------------------------------------------------------
module dwrk_dpath #(
   parameter int DEPTH = dwrk_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_cmd,
   input  logic [dwrk_pkg::KEY_W-1:0]   req_record_key,
   input  logic [dwrk_pkg::DATA_W-1:0]  req_record_payload,
   input  dwrk_pkg::dp_cmd_type         cmd,
   output dwrk_pkg::dp_sts_type         sts,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output logic [dwrk_pkg::KEY_W-1:0]   rsp_front_key,
   output logic [dwrk_pkg::DATA_W-1:0]  rsp_front_data,
   output logic [dwrk_pkg::KEY_W-1:0]   rsp_back_key,
   output logic [dwrk_pkg::DATA_W-1:0]  rsp_back_data
);

   import dwrk_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [DATA_W-1:0]  payload_ff;
   logic [IW-1:0]      head_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      pos_ff;
   status_type         status_ff;
   logic [KEY_W-1:0]   front_key_ff;
   logic [DATA_W-1:0]  front_data_ff;
   logic [KEY_W-1:0]   back_key_ff;
   logic [DATA_W-1:0]  back_data_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic               rsp_is_empty_ff;
   logic [CW-1:0]      rsp_occupancy_ff;
   logic [KEY_W-1:0]   rsp_front_key_ff;
   logic [DATA_W-1:0]  rsp_front_data_ff;
   logic [KEY_W-1:0]   rsp_back_key_ff;
   logic [DATA_W-1:0]  rsp_back_data_ff;

   logic [IW-1:0]      head_inc;
   logic [IW-1:0]      head_dec;
   logic [CW-1:0]      pos_next;
   logic [IW-1:0]      ram_addr;
   logic [REC_W-1:0]   ram_wdata;
   logic [REC_W-1:0]   ram_rdata;

   // ring slot of logical position pos from the front
   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] head,
                                             input logic [CW-1:0] pos);
      logic [IW:0] sum;
      sum = {1'b0, head} + {1'b0, pos[IW-1:0]};
      if (sum >= (IW+1)'(DEPTH)) sum = sum - (IW+1)'(DEPTH);
      return sum[IW-1:0];
   endfunction

   assign head_inc = (head_ff == IW'(DEPTH-1)) ? '0 : head_ff + IW'(1);
   assign head_dec = (head_ff == '0) ? IW'(DEPTH-1) : head_ff - IW'(1);
   assign pos_next = pos_ff + CW'(1);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_POS:      ram_addr = slot_of(head_ff, pos_ff);
         ADDR_POS_NEXT: ram_addr = slot_of(head_ff, pos_next);
         ADDR_TAIL:     ram_addr = slot_of(head_ff, count_ff);
         ADDR_NEW_HEAD: ram_addr = head_dec;
         ADDR_FRONT:    ram_addr = head_ff;
         ADDR_BACK:     ram_addr = slot_of(head_ff, count_ff - CW'(1));
         default:       ram_addr = head_ff;
      endcase
   end

   assign ram_wdata = cmd.wr_from_mem ? ram_rdata : {key_ff, payload_ff};

   dwrk_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (cmd.mem_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // status to the controller
   assign sts.op         = op_ff;
   assign sts.full       = (count_ff == CW'(DEPTH));
   assign sts.empty      = (count_ff == '0);
   assign sts.key_hit    = (ram_rdata[REC_W-1 -: KEY_W] == key_ff);
   assign sts.scan_last  = (pos_next >= count_ff);
   assign sts.shift_last = (({1'b0, pos_ff} + (CW+1)'(2)) >= {1'b0, count_ff});
   assign sts.rsp_busy   = rsp_valid_ff && rsp_stall;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.head_inc)      head_ff <= head_inc;
         else if (cmd.head_dec) head_ff <= head_dec;
         if (cmd.count_inc)      count_ff <= count_ff + CW'(1);
         else if (cmd.count_dec) count_ff <= count_ff - CW'(1);
         if (cmd.rsp_load)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)    rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= op_type'(req_cmd);
         key_ff     <= req_record_key;
         payload_ff <= req_record_payload;
      end
      if (cmd.pos_clr)      pos_ff <= '0;
      else if (cmd.pos_inc) pos_ff <= pos_next;
      if (cmd.status_we) status_ff <= cmd.status_val;
      if (cmd.view_clr) begin
         front_key_ff  <= '0;
         front_data_ff <= '0;
         back_key_ff   <= '0;
         back_data_ff  <= '0;
      end
      if (cmd.front_cap) begin
         front_key_ff  <= ram_rdata[REC_W-1 -: KEY_W];
         front_data_ff <= ram_rdata[DATA_W-1:0];
      end
      if (cmd.back_cap) begin
         back_key_ff  <= ram_rdata[REC_W-1 -: KEY_W];
         back_data_ff <= ram_rdata[DATA_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff     <= status_ff;
         rsp_is_empty_ff   <= (count_ff == '0);
         rsp_occupancy_ff  <= count_ff;
         rsp_front_key_ff  <= front_key_ff;
         rsp_front_data_ff <= front_data_ff;
         rsp_back_key_ff   <= back_key_ff;
         rsp_back_data_ff  <= back_data_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;
   assign rsp_occupancy  = rsp_occupancy_ff;
   assign rsp_front_key  = rsp_front_key_ff;
   assign rsp_front_data = rsp_front_data_ff;
   assign rsp_back_key   = rsp_back_key_ff;
   assign rsp_back_data  = rsp_back_data_ff;

endmodule

/* design/deque_with_remove_by_key_core.sv */
// ----------------------------------------------------------------------------
// deque_with_remove_by_key_core
// bounded double-ended record queue with delete of the first matching key
// ----------------------------------------------------------------------------
// Holds up to DEPTH records (24-bit key, 32-bit payload) in a ring kept in a
// single-port ram with registered read. Each item runs push back, push front,
// pop front or remove by key and answers with one result item: status,
// empty flag, occupancy and the front and back records (zero when empty).
// One item is in work at a time. Remove by key reads and compares the records
// from the front one by one and, on the first match, moves every later record
// one place toward the front to close the gap. The single ram port allows one
// access per cycle. A result waits in an output register, so a stalled result
// only holds back the end of the following item.
// ----------------------------------------------------------------------------
`include "deque_with_remove_by_key_core_macros.svh"

module deque_with_remove_by_key_core #(
   parameter int DEPTH = dwrk_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [dwrk_pkg::KEY_W-1:0]   req_record_key,
   input  logic [dwrk_pkg::DATA_W-1:0]  req_record_payload,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output logic [dwrk_pkg::KEY_W-1:0]   rsp_front_key,
   output logic [dwrk_pkg::DATA_W-1:0]  rsp_front_data,
   output logic [dwrk_pkg::KEY_W-1:0]   rsp_back_key,
   output logic [dwrk_pkg::DATA_W-1:0]  rsp_back_data
);

   import dwrk_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // sequencer: one state per ram access, waits in done for the output slot
   dwrk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // ring pointers, record ram and the response register
   dwrk_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_record_key     (req_record_key),
      .req_record_payload (req_record_payload),
      .cmd                (dp_cmd),
      .sts                (dp_sts),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_front_key      (rsp_front_key),
      .rsp_front_data     (rsp_front_data),
      .rsp_back_key       (rsp_back_key),
      .rsp_back_data      (rsp_back_data)
   );

   // one item in work at a time
   `DWRK_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request accepted while an item was in work")
   // count never passes the capacity
   `DWRK_ASSERT_IMPL(a_occupancy_bound, clock, reset, rsp_valid, rsp_occupancy <= CW'(DEPTH), "occupancy above capacity")
   // refused push only when the store is full
   `DWRK_ASSERT_IMPL(a_full_status, clock, reset, rsp_valid && rsp_status == ST_FULL, rsp_occupancy == CW'(DEPTH), "full status with free space")
   // empty flag follows the count and the readout is cleared
   `DWRK_ASSERT_IMPL(a_empty_view, clock, reset, rsp_valid && rsp_is_empty, rsp_occupancy == '0 && rsp_front_key == '0 && rsp_back_key == '0 && rsp_front_data == '0 && rsp_back_data == '0, "empty result with stale contents")

endmodule
